// ===== sv/xvtt_pkg.sv =====
// Package for the XOR-verified transposition table.
// Types, codes and sizes shared by the table logic; no dependencies.
`default_nettype none

package xvtt_pkg;

	localparam int unsigned TABLE_ENTRIES = 65536;
	localparam int unsigned SCORE_BIAS    = 32000;
	localparam int unsigned IDX_W         = $clog2(TABLE_ENTRIES);
	localparam int unsigned COUNT_W       = 17;
	localparam int unsigned SCORE_W       = 22;
	localparam int unsigned ENTRY_W       = 128;

	// operation codes
	localparam logic [1:0] OP_LOOKUP = 2'd0;
	localparam logic [1:0] OP_STORE  = 2'd1;
	localparam logic [1:0] OP_CLEAR  = 2'd2;

	// bound kinds
	localparam logic [1:0] KIND_EXACT = 2'd0;
	localparam logic [1:0] KIND_UPPER = 2'd1;
	localparam logic [1:0] KIND_LOWER = 2'd2;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ACCESS,
		ST_CLEAR
	} state_t;

	typedef struct packed {
		logic        [1:0]  op;
		logic        [63:0] hash_key;
		logic signed [7:0]  search_depth;
		logic signed [15:0] window_low;
		logic signed [15:0] window_high;
		logic        [1:0]  bound_kind;
		logic signed [15:0] score_in;
		logic        [31:0] move_in;
	} req_word_t;

	typedef struct packed {
		logic                 hit;
		logic        [31:0]   move_out;
		logic                 score_known;
		logic signed [15:0]   score_out;
		logic [COUNT_W-1:0]   filled_count;
	} rsp_word_t;

endpackage

`default_nettype wire

// ===== sv/xor_verified_transposition_table.sv =====
// Lookup and store: memory read, then check/write back, one word at a time.
// Clear: the request word is answered at once, then a sweep over all TABLE_ENTRIES slots
// (65536) zeroes the table while req_stall stays high.
// Reset: arst_n clears control state and starts the same clearing
// sweep; no response is produced for it and req_stall is high until it ends.
// Response sits in an output register, so it can wait on rsp_stall. Depends on xvtt_pkg.
`default_nettype none

module xor_verified_transposition_table (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   req_valid,
	output logic                  req_stall,
	input  wire xvtt_pkg::req_word_t req,
	output logic                  rsp_valid,
	input  wire                   rsp_stall,
	output xvtt_pkg::rsp_word_t   rsp
);
	import xvtt_pkg::*;

	// Each entry: key XOR data word in the upper half, packed data word in the lower half.
	logic [ENTRY_W-1:0] mem [TABLE_ENTRIES];

	state_t             state_q, state_d;
	logic [IDX_W-1:0]   clr_idx_q, clr_idx_d;
	logic [COUNT_W-1:0] filled_q, filled_d;
	req_word_t          item_q;
	logic [ENTRY_W-1:0] rd_data_q;
	logic               rsp_valid_q;
	rsp_word_t          rsp_q, rsp_d;

	logic               accept;
	logic               rsp_free;
	logic               load_rsp;
	logic               mem_we;
	logic [IDX_W-1:0]   mem_waddr;
	logic [ENTRY_W-1:0] mem_wdata;

	// lookup / store datapath
	logic [63:0]        rd_key, rd_dat;
	logic               hit_c, empty_c, depth_eq;
	logic signed [7:0]  ent_depth;
	logic [1:0]         ent_kind;
	logic signed [SCORE_W:0] ent_score;
	logic signed [SCORE_W:0] alpha_x, beta_x;
	logic signed [15:0] exact_sat;
	logic [SCORE_W-1:0] biased;
	logic [63:0]        new_dat;

	assign accept    = req_valid && !req_stall;
	assign req_stall = (state_q != ST_IDLE);
	assign rsp_free  = !rsp_valid_q || !rsp_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// memory: one write port, one registered read port addressed straight from the request
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (accept) begin
			rd_data_q <= mem[req.hash_key[IDX_W-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= req;
		end
		if (load_rsp) begin
			rsp_q <= rsp_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_idx_q   <= '0;
			filled_q    <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			clr_idx_q <= clr_idx_d;
			filled_q  <= filled_d;
			if (load_rsp) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Entry decode and new-word packing
	always_comb begin
		rd_key    = rd_data_q[ENTRY_W-1:64];
		rd_dat    = rd_data_q[63:0];
		hit_c     = ((rd_key ^ rd_dat) == item_q.hash_key);
		empty_c   = (rd_key == 64'd0) && (rd_dat == 64'd0);
		ent_depth = signed'(rd_dat[39:32]);
		ent_kind  = rd_dat[41:40];
		ent_score = signed'({1'b0, rd_dat[63:42]}) - signed'((SCORE_W+1)'(SCORE_BIAS));
		depth_eq  = (ent_depth == item_q.search_depth);
		alpha_x   = (SCORE_W+1)'(item_q.window_low);
		beta_x    = (SCORE_W+1)'(item_q.window_high);
		if (ent_score > (SCORE_W+1)'(32767)) begin
			exact_sat = 16'sh7FFF;
		end else if (ent_score < -(SCORE_W+1)'(32768)) begin
			exact_sat = -16'sh8000;
		end else begin
			exact_sat = ent_score[15:0];
		end
		biased  = SCORE_W'(item_q.score_in) + SCORE_W'(SCORE_BIAS);
		new_dat = {biased, item_q.bound_kind, item_q.search_depth, item_q.move_in};
	end

	// Sequencer: next state, memory write and response
	always_comb begin
		state_d   = state_q;
		clr_idx_d = clr_idx_q;
		filled_d  = filled_q;
		load_rsp  = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = item_q.hash_key[IDX_W-1:0];
		mem_wdata = {item_q.hash_key ^ new_dat, new_dat};
		rsp_d     = '0;
		rsp_d.filled_count = filled_q;

		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = ST_ACCESS;
				end
			end
			ST_ACCESS: begin
				if (rsp_free) begin
					load_rsp = 1'b1;
					state_d  = ST_IDLE;
					case (item_q.op)
						OP_LOOKUP: begin
							if (hit_c) begin
								rsp_d.hit      = 1'b1;
								rsp_d.move_out = rd_dat[31:0];
								if (depth_eq) begin
									case (ent_kind)
										KIND_EXACT: begin
											rsp_d.score_known = 1'b1;
											rsp_d.score_out   = exact_sat;
										end
										KIND_UPPER: begin
											if (ent_score <= alpha_x) begin
												rsp_d.score_known = 1'b1;
												rsp_d.score_out   = item_q.window_low;
											end
										end
										KIND_LOWER: begin
											if (ent_score >= beta_x) begin
												rsp_d.score_known = 1'b1;
												rsp_d.score_out   = item_q.window_high;
											end
										end
										default: ;
									endcase
								end
							end
						end
						OP_STORE: begin
							mem_we = 1'b1;
							if (empty_c && (filled_q != {COUNT_W{1'b1}})) begin
								filled_d = filled_q + 1'b1;
							end
							rsp_d.filled_count = filled_d;
						end
						OP_CLEAR: begin
							filled_d           = '0;
							rsp_d.filled_count = '0;
							clr_idx_d          = '0;
							state_d            = ST_CLEAR;
						end
						default: ;
					endcase
				end
			end
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_idx_q;
				mem_wdata = '0;
				clr_idx_d = clr_idx_q + 1'b1;
				if (clr_idx_q == {IDX_W{1'b1}}) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// A response only ever appears out of the access cycle.
	a_rsp_from_access: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q == ST_ACCESS))
		else $error("response raised outside access cycle");

	// An accepted word always moves on to the memory access.
	a_accept_to_access: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_ACCESS))
		else $error("accepted word did not reach access");

	// Fill counter is zero throughout any clearing sweep.
	a_clear_count_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> (filled_q == '0))
		else $error("fill count nonzero during clear");

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
// Self-checking bench for the XOR-verified transposition table.
// Holds its own copy of the table to predict every response word.
// Needs xvtt_pkg and the table RTL.
module tb;
	import xvtt_pkg::*;

	// codes the package leaves unnamed
	localparam logic [1:0] OP_UNUSED  = 2'd3;
	localparam logic [1:0] KIND_NONE  = 2'd3;
	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
	localparam int IDLE_PCT     = 38;
	localparam int HOLDOFF_CYC  = 400;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      req_valid = 1'b0;
	logic      req_stall;
	req_word_t req_w = '0;
	logic      rsp_valid;
	logic      rsp_stall = 1'b0;
	rsp_word_t rsp;

	// shadow table: slot contents and the fill counter
	bit [63:0]        key_mem  [TABLE_ENTRIES];
	bit [63:0]        data_mem [TABLE_ENTRIES];
	bit [COUNT_W-1:0] filled_cnt;

	req_word_t req_backlog[$];   // words waiting to be offered
	rsp_word_t due_rsp_q[$];     // predicted responses, oldest first
	req_word_t stored_pool[$];   // recent stores, reused to aim lookups at live slots

	int   words_sent = 0;
	int   mismatch_count = 0;
	logic hold_rsp = 1'b0;
	wire  calm = (words_sent >= 700) && (words_sent < 1000);  // no idling on either side

	xor_verified_transposition_table i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req_w),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Apply one word to the shadow table and return the response it should produce.
	function automatic rsp_word_t apply_table_op(input req_word_t w);
		rsp_word_t          r;
		logic [IDX_W-1:0]   slot;
		logic [63:0]        d;
		logic [63:0]        k;
		logic [63:0]        packed_w;
		logic [SCORE_W-1:0] biased;
		logic signed [7:0]  ent_depth;
		int unsigned        raw;
		int                 ent_score;
		r = '0;
		slot = w.hash_key[IDX_W-1:0];
		d = data_mem[slot];
		k = key_mem[slot];
		case (w.op)
			OP_LOOKUP: begin
				if ((k ^ d) == w.hash_key) begin
					r.hit = 1'b1;
					r.move_out = d[31:0];
					ent_depth = d[39:32];
					raw = 32'(d[63:42]);
					ent_score = int'(raw) - int'(SCORE_BIAS);
					if (ent_depth == w.search_depth) begin
						case (d[41:40])
							KIND_EXACT: begin
								// wrapped scores unpack far out of range and clamp
								if (ent_score > 32767)
									ent_score = 32767;
								else if (ent_score < -32768)
									ent_score = -32768;
								r.score_known = 1'b1;
								r.score_out = 16'(ent_score);
							end
							KIND_UPPER: begin
								if (ent_score <= int'(w.window_low)) begin
									r.score_known = 1'b1;
									r.score_out = w.window_low;
								end
							end
							KIND_LOWER: begin
								if (ent_score >= int'(w.window_high)) begin
									r.score_known = 1'b1;
									r.score_out = w.window_high;
								end
							end
							default: ;
						endcase
					end
				end
			end
			OP_STORE: begin
				// all-zero slot counts as empty, even if a store left it that way
				if (k == 64'd0 && d == 64'd0 && filled_cnt != COUNT_MAX)
					filled_cnt++;
				biased = SCORE_W'(int'(w.score_in) + int'(SCORE_BIAS));
				packed_w = {biased, w.bound_kind, w.search_depth, w.move_in};
				key_mem[slot] = w.hash_key ^ packed_w;
				data_mem[slot] = packed_w;
			end
			OP_CLEAR: begin
				for (int i = 0; i < TABLE_ENTRIES; i++) begin
					key_mem[i] = 64'd0;
					data_mem[i] = 64'd0;
				end
				filled_cnt = '0;
			end
			default: ;
		endcase
		r.filled_count = filled_cnt;
		return r;
	endfunction

	task automatic check_response(input rsp_word_t got);
		rsp_word_t want;
		if (due_rsp_q.size() == 0) begin
			mismatch_count++;
			if (mismatch_count <= 10)
				$display("%0t: unexpected word: hit=%0d move=%h known=%0d score=%0d count=%0d",
					$time, got.hit, got.move_out, got.score_known, got.score_out, got.filled_count);
		end else begin
			want = due_rsp_q.pop_front();
			if (got.hit !== want.hit || got.move_out !== want.move_out ||
			    got.score_known !== want.score_known || got.score_out !== want.score_out ||
			    got.filled_count !== want.filled_count) begin
				mismatch_count++;
				if (mismatch_count <= 10) begin
					$display("%0t: response mismatch", $time);
					$display("  got  hit=%0d move=%h known=%0d score=%0d count=%0d",
						got.hit, got.move_out, got.score_known, got.score_out, got.filled_count);
					$display("  want hit=%0d move=%h known=%0d score=%0d count=%0d",
						want.hit, want.move_out, want.score_known, want.score_out, want.filled_count);
				end
			end
		end
	endtask

	// Driver: holds a word until accepted, otherwise idles at random.
	always @(posedge clk) begin : drive_req
		if (arst_n) begin
			if (req_valid && !req_stall) begin
				due_rsp_q.push_back(apply_table_op(req_w));
				words_sent <= words_sent + 1;
			end
			if (!req_valid || !req_stall) begin
				if (req_backlog.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
					req_w <= req_backlog.pop_front();
					req_valid <= 1'b1;
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: checks each accepted response word and throttles the output.
	always @(posedge clk) begin : watch_rsp
		if (arst_n) begin
			if (rsp_valid && !rsp_stall)
				check_response(rsp);
			rsp_stall <= hold_rsp || (!calm && $urandom_range(99) < IDLE_PCT);
		end
	end

	// Long receiver hold-off while the sender keeps offering: fills the pipe and
	// forces the input to stall.
	initial begin : rsp_holdoff
		do @(negedge clk); while (words_sent < 300);
		hold_rsp = 1'b1;
		repeat (HOLDOFF_CYC) @(posedge clk);
		@(negedge clk);
		hold_rsp = 1'b0;
	end

	function automatic req_word_t random_fields();
		req_word_t w;
		w.op           = 2'($urandom);
		w.hash_key     = {$urandom, $urandom};
		w.search_depth = 8'($urandom);
		w.window_low   = 16'($urandom);
		w.window_high  = 16'($urandom);
		w.bound_kind   = 2'($urandom);
		w.score_in     = 16'($urandom);
		w.move_in      = $urandom;
		return w;
	endfunction

	task automatic add_lookup(input logic [63:0] hash, input logic signed [7:0] depth,
			input logic signed [15:0] lo, input logic signed [15:0] hi);
		req_word_t w;
		w = '0;
		w.op = OP_LOOKUP;
		w.hash_key = hash;
		w.search_depth = depth;
		w.window_low = lo;
		w.window_high = hi;
		req_backlog.push_back(w);
	endtask

	task automatic add_store(input logic [63:0] hash, input logic signed [7:0] depth,
			input logic [1:0] kind, input logic signed [15:0] score, input logic [31:0] move);
		req_word_t w;
		w = '0;
		w.op = OP_STORE;
		w.hash_key = hash;
		w.search_depth = depth;
		w.bound_kind = kind;
		w.score_in = score;
		w.move_in = move;
		req_backlog.push_back(w);
	endtask

	task automatic add_op(input logic [1:0] op);
		req_word_t w;
		w = random_fields();
		w.op = op;
		req_backlog.push_back(w);
	endtask

	// Mostly stores into a crowded index range and lookups aimed at what was stored,
	// with depth and window chosen so the bound rules fire on both sides.
	task automatic queue_random_words(input int count);
		req_word_t w;
		req_word_t ref_w;
		int        pick;
		int        sub;
		repeat (count) begin
			w = random_fields();
			pick = $urandom_range(99);
			sub = $urandom_range(99);
			if (pick < 3) begin
				w.op = OP_UNUSED;
			end else if (pick < 45) begin
				w.op = OP_STORE;
				if (stored_pool.size() != 0 && sub < 25)
					w.hash_key = stored_pool[$urandom_range(stored_pool.size() - 1)].hash_key;
				else if (sub < 80)
					w.hash_key[IDX_W-1:0] = IDX_W'($urandom_range(511));
				if ($urandom_range(3) != 0)
					w.search_depth = 8'($urandom_range(3));
				if ($urandom_range(3) != 0)
					w.score_in = 16'(int'($urandom_range(64000)) - 32000);
				if ($urandom_range(3) != 0)
					w.bound_kind = 2'($urandom_range(2));
				stored_pool.push_back(w);
				if (stored_pool.size() > 48)
					void'(stored_pool.pop_front());
			end else begin
				w.op = OP_LOOKUP;
				if (stored_pool.size() != 0 && sub < 80) begin
					ref_w = stored_pool[$urandom_range(stored_pool.size() - 1)];
					w.hash_key = ref_w.hash_key;
					if (sub < 70) begin
						if ($urandom_range(4) != 0)
							w.search_depth = ref_w.search_depth;
						if ($urandom_range(4) != 0)
							w.window_low = 16'(int'(ref_w.score_in) + int'($urandom_range(8)) - 4);
						if ($urandom_range(4) != 0)
							w.window_high = 16'(int'(ref_w.score_in) + int'($urandom_range(8)) - 4);
					end else begin
						// same slot, different upper hash bits: must miss
						w.hash_key = w.hash_key ^ (64'd1 << $urandom_range(63, IDX_W));
					end
				end else if (sub < 90) begin
					w.hash_key[IDX_W-1:0] = IDX_W'($urandom_range(511));
				end
			end
			req_backlog.push_back(w);
		end
	endtask

	task automatic wait_drained();
		do @(negedge clk);
		while (req_backlog.size() != 0 || req_valid || due_rsp_q.size() != 0);
	endtask

	initial begin : stimulus
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// empty slot hit: hash zero matches an all-zero slot, exact score at the bias floor
		add_lookup(64'd0, 8'sd0, 16'sd0, 16'sd0);
		add_lookup(64'hFFFF_FFFF_FFFF_FFFF, 8'sd0, 16'sd0, 16'sd0);
		// extremes of move, depth and score
		add_store(64'hFFFF_FFFF_FFFF_FFFF, 8'sd127, KIND_EXACT, 16'sd32767, 32'hFFFF_FFFF);
		add_lookup(64'hFFFF_FFFF_FFFF_FFFF, 8'sd127, -16'sd32768, 16'sd32767);
		add_lookup(64'hFFFF_FFFF_FFFF_FFFF, -8'sd128, 16'sd0, 16'sd0);
		// upper bound at and just past alpha
		add_store(64'h0123_4567_89AB_0010, -8'sd128, KIND_UPPER, -16'sd100, 32'd1);
		add_lookup(64'h0123_4567_89AB_0010, -8'sd128, -16'sd100, 16'sd0);
		add_lookup(64'h0123_4567_89AB_0010, -8'sd128, -16'sd101, 16'sd0);
		// same slot, other hash
		add_lookup(64'h0123_4567_89AC_0010, -8'sd128, -16'sd100, 16'sd0);
		// lower bound at and just past beta
		add_store(64'h8000_0000_0000_0020, 8'sd5, KIND_LOWER, 16'sd500, 32'd2);
		add_lookup(64'h8000_0000_0000_0020, 8'sd5, 16'sd0, 16'sd500);
		add_lookup(64'h8000_0000_0000_0020, 8'sd5, 16'sd0, 16'sd501);
		// bound kind three never scores
		add_store(64'h5A5A_5A5A_5A5A_0030, 8'sd1, KIND_NONE, 16'sd0, 32'h8000_0000);
		add_lookup(64'h5A5A_5A5A_5A5A_0030, 8'sd1, 16'sd32767, -16'sd32768);
		// biased score wraps below zero, exact readback clamps
		add_store(64'h7000_0000_0000_0040, 8'sd0, KIND_EXACT, -16'sd32768, 32'd3);
		add_lookup(64'h7000_0000_0000_0040, 8'sd0, 16'sd0, 16'sd0);
		// overwrite of a filled slot leaves the count alone
		add_store(64'h7000_0000_0000_0040, 8'sd0, KIND_EXACT, 16'sd32000, 32'd4);
		add_lookup(64'h7000_0000_0000_0040, 8'sd0, 16'sd0, 16'sd0);
		// store that leaves the slot all zero: counted again each time
		add_store(64'd0, 8'sd0, KIND_EXACT, -16'sd32000, 32'd0);
		add_store(64'd0, 8'sd0, KIND_EXACT, -16'sd32000, 32'd0);
		add_lookup(64'd0, 8'sd0, 16'sd0, 16'sd0);
		add_op(OP_UNUSED);
		add_op(OP_CLEAR);
		add_lookup(64'hFFFF_FFFF_FFFF_FFFF, 8'sd127, 16'sd0, 16'sd0);
		add_store(64'hFFFF_FFFF_FFFF_FFFF, 8'sd3, KIND_LOWER, 16'sd7, 32'd5);

		// sender pause until every response is back
		wait_drained();

		queue_random_words(500);
		add_op(OP_CLEAR);
		stored_pool.delete();
		queue_random_words(300);
		wait_drained();
		queue_random_words(400);
		add_op(OP_CLEAR);
		stored_pool.delete();
		queue_random_words(400);

		wait_drained();
		repeat (10) @(posedge clk);
		if (mismatch_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	// the timeout leaves room for four clearing sweeps plus the words
	initial begin : watchdog
		#20_000_000;
		$display("FAILURE");
		$finish;
	end

endmodule
